// ===== design/per_cpu_page_free_list_with_steal_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-CPU page free list
// Shared concurrent assertion forms, sampled on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_PAGE_FREE_LIST_WITH_STEAL_ASSERT_SVH
`define PER_CPU_PAGE_FREE_LIST_WITH_STEAL_ASSERT_SVH

// A condition that must hold at every clock edge.
`define PCPFL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pcpfl assertion failed");

// A condition that must hold in the same cycle as its trigger.
`define PCPFL_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcpfl assertion failed");

// A condition that must hold in the cycle after its trigger.
`define PCPFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcpfl assertion failed");

`endif

// ===== design/pcpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpfl_pkg
// Types and constants shared by the per-CPU page free list modules.
// ----------------------------------------------------------------------------
package pcpfl_pkg;

    // Default sizes of the managed pool.
    localparam int NUM_PAGES_DEF = 1024;
    localparam int NUM_CPUS_DEF  = 8;

    // Fixed field widths of the request and result words.
    localparam int PAGE_W   = 10;
    localparam int CPU_IN_W = 3;
    localparam int STATUS_W = 2;

    // Request operation codes.
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_MEM   = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    // What the request in flight does to the lists; at most one flag is set.
    typedef struct packed {
        logic pop;
        logic push;
        logic no_mem;
        logic bad_free;
    } act_t;

endpackage

// ===== design/pcpfl_ram.sv =====
// ----------------------------------------------------------------------------
// pcpfl_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module pcpfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on request; the read port always returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pcpfl_clear.sv =====
// ----------------------------------------------------------------------------
// pcpfl_clear
// Start-up sweep that writes the initial list chains into the link store.
// ----------------------------------------------------------------------------
module pcpfl_clear #(
    parameter int NUM_PAGES = pcpfl_pkg::NUM_PAGES_DEF,
    parameter int NUM_CPUS  = pcpfl_pkg::NUM_CPUS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    output logic                             busy,
    output logic [$clog2(NUM_PAGES)-1:0]     addr,
    output logic [$clog2(NUM_PAGES+1)-1:0]   wdata
);

    import pcpfl_pkg::*;

    localparam int ADDR_W = $clog2(NUM_PAGES);
    localparam int LINK_W = $clog2(NUM_PAGES + 1);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_PAGES - 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PAGES);

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;

    // Walk every page once, then stop for good.
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (busy_reg)
        begin
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Page j links to page j minus the CPU count; the lowest pages end their lists.
    always_comb
    begin
        if (32'(idx_reg) >= 32'(NUM_CPUS))
        begin
            wdata = LINK_W'(32'(idx_reg) - 32'(NUM_CPUS));
        end
        else
        begin
            wdata = NULL_LINK;
        end
    end

    assign busy = busy_reg;
    assign addr = idx_reg;

endmodule

// ===== design/pcpfl_select.sv =====
// ----------------------------------------------------------------------------
// pcpfl_select
// Decides what a request does: own pop, steal, push, or an error.
// ----------------------------------------------------------------------------
module pcpfl_select #(
    parameter int NUM_PAGES = pcpfl_pkg::NUM_PAGES_DEF,
    parameter int NUM_CPUS  = pcpfl_pkg::NUM_CPUS_DEF
) (
    input  logic [$clog2(NUM_PAGES+1)-1:0]            heads [NUM_CPUS],
    input  pcpfl_pkg::opcode_t                        op,
    input  logic [((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)-1:0] cpu,
    input  logic [pcpfl_pkg::PAGE_W-1:0]              page,
    output pcpfl_pkg::act_t                           act,
    output logic [((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)-1:0] sel_cpu,
    output logic [$clog2(NUM_PAGES+1)-1:0]            sel_head
);

    import pcpfl_pkg::*;

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int LINK_W = $clog2(NUM_PAGES + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PAGES);

    logic             found;
    logic [CPU_W-1:0] first_cpu;
    logic             own_ok;

    // Lowest-numbered non-empty list; the loop runs downwards so the lowest wins.
    always_comb
    begin
        found     = 1'b0;
        first_cpu = '0;
        for (int c = NUM_CPUS - 1; c >= 0; c--)
        begin
            if (heads[c] != NULL_LINK)
            begin
                found     = 1'b1;
                first_cpu = CPU_W'(c);
            end
        end
    end

    // The own list wins; when it is empty the first non-empty list is another CPU's.
    assign own_ok   = (heads[cpu] != NULL_LINK);
    assign sel_cpu  = own_ok ? cpu : first_cpu;
    assign sel_head = heads[sel_cpu];

    // Classify the request.
    always_comb
    begin
        act = '0;
        if (op == OP_FREE)
        begin
            if (32'(page) >= 32'(NUM_PAGES))
            begin
                act.bad_free = 1'b1;
            end
            else
            begin
                act.push = 1'b1;
            end
        end
        else if (found)
        begin
            act.pop = 1'b1;
        end
        else
        begin
            act.no_mem = 1'b1;
        end
    end

endmodule

// ===== design/per_cpu_page_free_list_with_steal.sv =====
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_with_steal
// Page allocator with one LIFO free list per CPU and stealing on an empty list.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (in_valid, in_stall) as opcode, cpu and page
// words; one result word (granted_page, status) leaves on the out channel
// (out_valid, out_stall) for each request, in request order.
// An allocate pops the requester's own list, else the head of the lowest
// numbered non-empty list, else reports out of memory. A free pushes the page
// onto the requester's list, or reports a bad free when it is out of range.
// A request waits in the input register until the result register can take it;
// it is then resolved against the list heads and shown from the next cycle on.
// One request is taken per cycle unless in_stall is high. Consecutive pops
// are fed by forwarding the link just read from the link store (a single-port
// RAM with registered read) straight into the head selection of the following
// request. After reset a sweep writes the start-up chains into the link store,
// one page per cycle until all NUM_PAGES pages are written; in_stall is high
// for that time. While out_stall holds the result, the input register keeps
// the next request and in_stall rises only when that register is also full.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_with_steal #(
    parameter int NUM_PAGES = pcpfl_pkg::NUM_PAGES_DEF,
    parameter int NUM_CPUS  = pcpfl_pkg::NUM_CPUS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [pcpfl_pkg::CPU_IN_W-1:0] cpu,
    input  logic [pcpfl_pkg::PAGE_W-1:0]   page,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pcpfl_pkg::PAGE_W-1:0]   granted_page,
    output logic [pcpfl_pkg::STATUS_W-1:0] status
);

    import pcpfl_pkg::*;

    `include "per_cpu_page_free_list_with_steal_assert.svh"

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int LINK_W = $clog2(NUM_PAGES + 1);
    localparam int ADDR_W = $clog2(NUM_PAGES);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PAGES);

    // Input register.
    logic              item_valid_reg;
    logic              item_valid_next;
    opcode_t           item_op_reg;
    logic [CPU_W-1:0]  item_cpu_reg;
    logic [PAGE_W-1:0] item_page_reg;

    // Result register.
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [PAGE_W-1:0] res_page_reg;
    logic [PAGE_W-1:0] res_page_next;
    status_t           res_status_reg;
    status_t           res_status_next;

    // List heads and the pop whose new head is still coming out of the RAM.
    logic [LINK_W-1:0] head_reg  [NUM_CPUS];
    logic [LINK_W-1:0] head_next [NUM_CPUS];
    logic [LINK_W-1:0] eff_head  [NUM_CPUS];
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [CPU_W-1:0]  pend_cpu_reg;

    // Link store port and start-up sweep.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;
    logic              clr_busy;
    logic [ADDR_W-1:0] clr_addr;
    logic [LINK_W-1:0] clr_wdata;

    // Decision for the request in the input register.
    act_t              act;
    logic [CPU_W-1:0]  sel_cpu;
    logic [LINK_W-1:0] sel_head;
    logic              advance;
    logic              in_acc;

    // Requesting CPU folded into range, one constant entry per input code.
    logic [CPU_W-1:0]  cpu_map [1 << CPU_IN_W];

    generate
        for (genvar i = 0; i < (1 << CPU_IN_W); i++)
        begin : g_cpu_map
            assign cpu_map[i] = CPU_W'(i % NUM_CPUS);
        end
    endgenerate

    // Handshake: resolve when the result register is free or being emptied.
    assign advance  = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = clr_busy || (item_valid_reg && !advance);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_acc)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !out_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign pend_valid_next = advance && act.pop;

    // Current heads, with the link read for the last pop forwarded in.
    generate
        for (genvar c = 0; c < NUM_CPUS; c++)
        begin : g_eff
            assign eff_head[c] = (pend_valid_reg && (pend_cpu_reg == CPU_W'(c))) ?
                                 ram_rdata : head_reg[c];
        end
    endgenerate

    pcpfl_select #(
        .NUM_PAGES (NUM_PAGES),
        .NUM_CPUS  (NUM_CPUS)
    ) u_select (
        .heads    (eff_head),
        .op       (item_op_reg),
        .cpu      (item_cpu_reg),
        .page     (item_page_reg),
        .act      (act),
        .sel_cpu  (sel_cpu),
        .sel_head (sel_head)
    );

    // Head updates: the pending pop lands first, a push on the same list overrides it.
    always_comb
    begin
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            head_next[c] = head_reg[c];
        end
        if (pend_valid_reg)
        begin
            head_next[pend_cpu_reg] = ram_rdata;
        end
        if (advance && act.push)
        begin
            head_next[item_cpu_reg] = LINK_W'(item_page_reg);
        end
    end

    // Link store port: sweep at start-up, push writes, otherwise read the popped link.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = ADDR_W'(sel_head);
        ram_wdata = eff_head[item_cpu_reg];
        if (clr_busy)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr;
            ram_wdata = clr_wdata;
        end
        else if (advance && act.push)
        begin
            ram_we   = 1'b1;
            ram_addr = ADDR_W'(item_page_reg);
        end
    end

    // Result word.
    always_comb
    begin
        res_page_next   = '0;
        res_status_next = ST_OK;
        if (act.pop)
        begin
            res_page_next = PAGE_W'(sel_head);
        end
        if (act.no_mem)
        begin
            res_status_next = ST_NO_MEM;
        end
        else if (act.bad_free)
        begin
            res_status_next = ST_BAD_FREE;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_op_reg   <= opcode_t'(opcode);
            item_cpu_reg  <= cpu_map[cpu];
            item_page_reg <= page;
        end
        if (advance)
        begin
            res_page_reg   <= res_page_next;
            res_status_reg <= res_status_next;
            pend_cpu_reg   <= sel_cpu;
        end
    end

    // Head registers; each list starts at the highest page of its share.
    generate
        for (genvar c = 0; c < NUM_CPUS; c++)
        begin : g_head
            localparam int SHARE_LOW = (c + NUM_CPUS - 1) % NUM_CPUS;
            localparam int HEAD_RST  = (SHARE_LOW >= NUM_PAGES) ? NUM_PAGES :
                SHARE_LOW + ((NUM_PAGES - 1 - SHARE_LOW) / NUM_CPUS) * NUM_CPUS;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    head_reg[c] <= LINK_W'(HEAD_RST);
                end
                else
                begin
                    head_reg[c] <= head_next[c];
                end
            end
        end
    endgenerate

    pcpfl_clear #(
        .NUM_PAGES (NUM_PAGES),
        .NUM_CPUS  (NUM_CPUS)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr),
        .wdata (clr_wdata)
    );

    pcpfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_valid    = res_valid_reg;
    assign granted_page = res_page_reg;
    assign status       = res_status_reg;

    // Checks on the internal decision and forwarding logic.
    `PCPFL_ASSERT_ALWAYS(a_no_item_while_clearing, !(clr_busy && item_valid_reg))
    `PCPFL_ASSERT_ALWAYS(a_one_action, !item_valid_reg || $onehot(act))
    `PCPFL_ASSERT_IMPLIES(a_pop_not_null, advance && act.pop, sel_head != NULL_LINK)
    `PCPFL_ASSERT_IMPLIES(a_oom_own_empty, advance && act.no_mem,
                          eff_head[item_cpu_reg] == NULL_LINK)
    `PCPFL_ASSERT_NEXT(a_pend_after_pop, advance && act.pop, pend_valid_reg)

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the per-CPU page free list with stealing
// Requests are planned up front against a planning copy of the pool, driven
// with random gaps and checked word by word against a live copy of the pool.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcpfl_pkg::*;

    localparam int NPAGE        = NUM_PAGES_DEF;
    localparam int NCPU         = NUM_CPUS_DEF;
    localparam int LINK_W       = $clog2(NPAGE) + 1;
    // Two copies of the pool: one steers stimulus, one predicts the results.
    localparam int PLAN         = 0;
    localparam int LIVE         = 1;
    localparam int TAIL_WORDS   = 60;
    localparam int HOLD_OFF     = 80;
    localparam int HOLD_AT      = 150;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE       = 20;

    typedef struct packed {
        opcode_t               op;
        logic [CPU_IN_W-1:0]   cpu;
        logic [PAGE_W-1:0]     page;
    } request_t;

    typedef struct packed {
        logic [PAGE_W-1:0]     granted;
        status_t               status;
    } grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  opcode = OP_ALLOC;
    logic [CPU_IN_W-1:0]   cpu = '0;
    logic [PAGE_W-1:0]     page = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PAGE_W-1:0]     granted_page;
    logic [STATUS_W-1:0]   status;

    // Heads and links of both pool copies.
    logic [LINK_W-1:0]     pool_head [2][NCPU];
    logic [LINK_W-1:0]     pool_link [2][NPAGE];

    request_t              pending_words[$];
    grant_t                expected_grants[$];
    logic [PAGE_W-1:0]     held_pages[$];

    logic                  word_taken = 1'b0;
    int                    send_gap = 0;
    int                    stall_left = 0;
    bit                    hold_done = 1'b0;
    int                    words_sent = 0;
    int                    total_words = 0;
    int                    grants_seen = 0;
    int                    mismatches = 0;
    int                    idle_cycles = 0;

    per_cpu_page_free_list_with_steal dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .cpu          (cpu),
        .page         (page),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted_page (granted_page),
        .status       (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Start-up fill: page j goes onto the list of CPU (j+1) mod NCPU, ascending.
    task automatic pool_reset(input int copy);
        int c;
        int j;
        for (c = 0; c < NCPU; c++)
            pool_head[copy][c] = LINK_W'(NPAGE);
        for (j = 0; j < NPAGE; j++)
        begin
            c = (j + 1) % NCPU;
            pool_link[copy][j] = pool_head[copy][c];
            pool_head[copy][c] = LINK_W'(j);
        end
    endtask

    // Applies one request to a pool copy and returns the result word it gives.
    function automatic grant_t serve_request(input int copy, input request_t r);
        grant_t             res;
        int                 own;
        int                 k;
        int                 c;
        logic [LINK_W-1:0]  top;
        bit                 got;
        res.granted = '0;
        res.status  = ST_OK;
        got         = 1'b0;
        own         = int'(r.cpu) % NCPU;
        if (r.op == OP_FREE)
        begin
            if (int'(r.page) >= NPAGE)
                res.status = ST_BAD_FREE;
            else
            begin
                pool_link[copy][r.page] = pool_head[copy][own];
                pool_head[copy][own]    = LINK_W'(r.page);
            end
        end
        else
        begin
            // The requester's own list first, then the others in ascending order.
            for (k = 0; k <= NCPU; k++)
            begin
                c   = (k == 0) ? own : k - 1;
                top = pool_head[copy][c];
                if (!got && (k == 0 || c != own) && int'(top) < NPAGE)
                begin
                    res.granted        = top[PAGE_W-1:0];
                    pool_head[copy][c] = pool_link[copy][top[PAGE_W-1:0]];
                    got                = 1'b1;
                end
            end
            if (!got)
                res.status = ST_NO_MEM;
        end
        return res;
    endfunction

    // Queues a request and keeps track of which pages are out on loan.
    task automatic plan_request(input opcode_t op, input int c, input int pg);
        request_t r;
        grant_t   res;
        int       i;
        r.op   = op;
        r.cpu  = CPU_IN_W'(c);
        r.page = PAGE_W'(pg);
        pending_words.push_back(r);
        total_words++;
        res = serve_request(PLAN, r);
        if (op == OP_ALLOC && res.status == ST_OK)
            held_pages.push_back(res.granted);
        else if (op == OP_FREE)
        begin
            for (i = 0; i < held_pages.size(); i++)
            begin
                if (held_pages[i] == r.page)
                begin
                    held_pages.delete(i);
                    break;
                end
            end
        end
    endtask

    // Frees a page that is currently on loan, onto a random CPU's list.
    task automatic plan_return();
        int idx;
        idx = $urandom_range(0, held_pages.size() - 1);
        plan_request(OP_FREE, $urandom_range(0, NCPU - 1), int'(held_pages[idx]));
    endtask

    // Sender: a new word goes out at the falling edge once the last one was taken.
    always @(negedge clk)
    begin : drive_requests
        request_t nxt;
        if (rst_n && !(in_valid && !word_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_words.size() >= TAIL_WORDS && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 12);
            end
            else if (pending_words.size() != 0)
            begin
                nxt      = pending_words.pop_front();
                in_valid <= 1'b1;
                opcode   <= nxt.op;
                cpu      <= nxt.cpu;
                page     <= nxt.page;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, and one long hold-off to fill the block.
    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!hold_done && grants_seen >= HOLD_AT)
            begin
                out_stall  <= 1'b1;
                stall_left <= HOLD_OFF - 1;
                hold_done  <= 1'b1;
            end
            else if (pending_words.size() >= TAIL_WORDS && $urandom_range(0, 7) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 12);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Rising edge: predict accepted requests, check accepted results, watch for hangs.
    always @(posedge clk)
    begin : check_grants
        request_t req;
        grant_t   want;
        bit       in_acc;
        bit       out_acc;
        if (rst_n)
        begin
            in_acc     = in_valid && !in_stall;
            out_acc    = out_valid && !out_stall;
            word_taken <= in_acc;
            if (in_acc)
            begin
                req.op   = opcode_t'(opcode);
                req.cpu  = cpu;
                req.page = page;
                expected_grants.push_back(serve_request(LIVE, req));
                words_sent++;
            end
            if (out_acc)
            begin
                grants_seen++;
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: unexpected result word, granted_page %0d status %0d",
                             $time, granted_page, status);
                    mismatches++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (granted_page !== want.granted)
                    begin
                        $display("%0t: granted_page expected %0d, actual %0d",
                                 $time, want.granted, granted_page);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, status);
                        mismatches++;
                    end
                end
            end
            idle_cycles = (in_acc || out_acc) ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("FAIL per_cpu_page_free_list_with_steal");
                $finish;
            end
        end
    end

    initial
    begin : run_test
        int  c;
        int  k;
        int  hot;
        bit  dry;
        pool_reset(PLAN);
        pool_reset(LIVE);

        // Opening words: every CPU allocates, then two frees, each followed by its re-allocation.
        for (c = 0; c < NCPU; c++)
            plan_request(OP_ALLOC, c, (c % 2 == 0) ? NPAGE - 1 : 0);
        plan_request(OP_FREE, 7, NPAGE - 1);
        plan_request(OP_ALLOC, 7, 0);
        plan_request(OP_FREE, 4, NPAGE - 8);
        plan_request(OP_ALLOC, 4, NPAGE - 1);

        // Drain the pool, mostly from one busy CPU at a time so that it steals.
        dry = 1'b0;
        k   = 0;
        hot = 0;
        while (!dry && k < 3000)
        begin
            if (k % 16 == 0)
                hot = $urandom_range(0, NCPU - 1);
            if (held_pages.size() != 0 && $urandom_range(0, 99) < 1)
                plan_return();
            else
                plan_request(OP_ALLOC,
                             ($urandom_range(0, 9) < 7) ? hot : $urandom_range(0, NCPU - 1),
                             $urandom_range(0, NPAGE - 1));
            dry = 1'b1;
            for (c = 0; c < NCPU; c++)
                if (int'(pool_head[PLAN][c]) < NPAGE)
                    dry = 1'b0;
            k++;
        end

        // Empty pool: out of memory, a single stolen page, and a double free.
        plan_request(OP_ALLOC, 3, 0);
        plan_request(OP_ALLOC, 0, NPAGE - 1);
        plan_request(OP_FREE, 6, 0);
        plan_request(OP_ALLOC, 2, 0);
        plan_request(OP_FREE, 2, NPAGE - 1);
        plan_request(OP_FREE, 5, NPAGE - 1);
        plan_request(OP_ALLOC, 5, 0);
        plan_request(OP_ALLOC, 2, 0);
        plan_request(OP_ALLOC, 7, 0);

        // Mixed traffic near empty, with a little noise of stray frees.
        for (k = 0; k < 30; k++)
        begin
            if ($urandom_range(0, 99) < 3)
                plan_request(OP_FREE, $urandom_range(0, NCPU - 1),
                             $urandom_range(0, NPAGE - 1));
            else if (held_pages.size() != 0 && $urandom_range(0, 99) < 55)
                plan_return();
            else
                plan_request(OP_ALLOC, $urandom_range(0, NCPU - 1),
                             $urandom_range(0, NPAGE - 1));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(words_sent == total_words && expected_grants.size() == 0))
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && expected_grants.size() == 0)
            $display("PASS per_cpu_page_free_list_with_steal");
        else
            $display("FAIL per_cpu_page_free_list_with_steal");
        $finish;
    end
endmodule
